### sv/assert_macros.svh
// assertion macros for the rtl of the i2c bit engine
// no dependencies; ASSERT_OFF removes every check

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### sv/i2cbe_pkg.sv
// types, codes and constants of the i2c bit engine
// no dependencies

package i2cbe_pkg;

  localparam int unsigned TickW  = 10;
  localparam int unsigned KindW  = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned PhaseW = 2;

  typedef enum logic [KindW-1:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  localparam logic [KindW-1:0]  KIND_TICK       = 3'd0;
  localparam logic [SlotW-1:0]  LAST_DATA_SLOT  = 4'd8;
  localparam logic [PhaseW-1:0] LAST_PHASE      = 2'd3;
  localparam logic [TickW-1:0]  PHASE_TICKS_RST = 10'd10;

  typedef struct packed {
    logic [TickW-1:0]  tick_count;
    logic [PhaseW-1:0] phase;
    logic [SlotW-1:0]  bit_index;
    logic [ByteW-1:0]  shift_reg;
    cmd_e              active_cmd;
    logic              ack_choice;
    logic              scl;
    logic              sda;
    logic              nack;
  } state_t;

  typedef struct packed {
    logic             scl_level;
    logic             sda_release;
    logic             busy_res;
    logic             done_res;
    logic             nack_seen;
    logic [ByteW-1:0] read_byte;
  } res_t;

endpackage

### sv/i2cbe_cmd_if.sv
// input channel of the i2c bit engine: tick and command words
// depends on i2cbe_pkg

interface i2cbe_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [i2cbe_pkg::KindW-1:0]   kind;
  logic [i2cbe_pkg::ByteW-1:0]   write_byte;
  logic                          send_ack;
  logic                          sda_in;

  modport source (output valid, kind, write_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, kind, write_byte, send_ack, sda_in, output ready);
endinterface

### sv/i2cbe_res_if.sv
// output channel of the i2c bit engine: pin levels and status words
// depends on i2cbe_pkg

interface i2cbe_res_if;
  logic                        valid;
  logic                        ready;
  logic                        scl_level;
  logic                        sda_release;
  logic                        busy_res;
  logic                        done_res;
  logic                        nack_seen;
  logic [i2cbe_pkg::ByteW-1:0] read_byte;

  modport source (output valid, scl_level, sda_release, busy_res, done_res, nack_seen,
                  read_byte, input ready);
  modport sink   (input valid, scl_level, sda_release, busy_res, done_res, nack_seen,
                  read_byte, output ready);
endinterface

### sv/i2cbe_step.sv
// next-state and result logic for one word of the i2c bit engine
// depends on i2cbe_pkg

module i2cbe_step (
  input  i2cbe_pkg::state_t                state_i,
  input  logic [i2cbe_pkg::TickW-1:0]      phase_ticks_i,
  input  logic [i2cbe_pkg::KindW-1:0]      kind_i,
  input  logic [i2cbe_pkg::ByteW-1:0]      write_byte_i,
  input  logic                             send_ack_i,
  input  logic                             sda_in_i,
  output i2cbe_pkg::state_t                state_o,
  output i2cbe_pkg::res_t                  res_o
);

  logic                           is_cmd;
  logic [i2cbe_pkg::TickW-1:0]    len;
  logic [i2cbe_pkg::TickW:0]      tick_inc;
  logic [i2cbe_pkg::SlotW-1:0]    last_slot;
  logic                           data_slot;
  logic                           scl_drv;
  logic                           sda_drv;
  logic                           done;
  logic                           nack_out;
  logic [i2cbe_pkg::ByteW-1:0]    byte_out;
  i2cbe_pkg::state_t              nxt;

  assign is_cmd    = (kind_i == i2cbe_pkg::CMD_START) || (kind_i == i2cbe_pkg::CMD_STOP) ||
                     (kind_i == i2cbe_pkg::CMD_WRITE) || (kind_i == i2cbe_pkg::CMD_READ);
  assign len       = (phase_ticks_i == '0) ? i2cbe_pkg::TickW'(1) : phase_ticks_i;
  assign tick_inc  = {1'b0, state_i.tick_count} + (i2cbe_pkg::TickW + 1)'(1);
  assign data_slot = state_i.bit_index < i2cbe_pkg::LAST_DATA_SLOT;
  assign last_slot = ((state_i.active_cmd == i2cbe_pkg::CMD_WRITE) ||
                      (state_i.active_cmd == i2cbe_pkg::CMD_READ)) ?
                     i2cbe_pkg::LAST_DATA_SLOT : '0;

  // pin levels for the current phase
  always_comb begin
    scl_drv = state_i.scl;
    sda_drv = state_i.sda;
    unique case (state_i.active_cmd)
      i2cbe_pkg::CMD_START: begin
        scl_drv = (state_i.phase == 2'd1) || (state_i.phase == 2'd2);
        sda_drv = state_i.phase < 2'd2;
      end
      i2cbe_pkg::CMD_STOP: begin
        scl_drv = state_i.phase >= 2'd1;
        sda_drv = state_i.phase >= 2'd2;
      end
      i2cbe_pkg::CMD_WRITE: begin
        scl_drv = state_i.phase >= 2'd2;
        sda_drv = data_slot ? state_i.shift_reg[i2cbe_pkg::ByteW-1] : 1'b1;
      end
      i2cbe_pkg::CMD_READ: begin
        scl_drv = state_i.phase >= 2'd2;
        sda_drv = data_slot ? 1'b1 : ~state_i.ack_choice;
      end
      default: begin
        scl_drv = state_i.scl;
        sda_drv = state_i.sda;
      end
    endcase
  end

  always_comb begin
    nxt      = state_i;
    done     = 1'b0;
    nack_out = 1'b0;
    byte_out = '0;
    if ((state_i.active_cmd == i2cbe_pkg::CMD_IDLE) && is_cmd) begin
      nxt.active_cmd = i2cbe_pkg::cmd_e'(kind_i);
      nxt.tick_count = '0;
      nxt.phase      = '0;
      nxt.bit_index  = '0;
      nxt.ack_choice = send_ack_i;
      nxt.shift_reg  = (kind_i == i2cbe_pkg::CMD_WRITE) ? write_byte_i : '0;
      if (kind_i == i2cbe_pkg::CMD_WRITE) begin
        nxt.nack = 1'b0;
      end
    end else if ((kind_i == i2cbe_pkg::KIND_TICK) &&
                 (state_i.active_cmd != i2cbe_pkg::CMD_IDLE)) begin
      nxt.scl = scl_drv;
      nxt.sda = sda_drv;
      if (tick_inc >= {1'b0, len}) begin
        nxt.tick_count = '0;
        if (state_i.phase == i2cbe_pkg::LAST_PHASE) begin
          if (state_i.active_cmd == i2cbe_pkg::CMD_WRITE) begin
            if (data_slot) begin
              nxt.shift_reg = {state_i.shift_reg[i2cbe_pkg::ByteW-2:0], 1'b0};
            end else begin
              nxt.nack = sda_in_i;
            end
          end else if ((state_i.active_cmd == i2cbe_pkg::CMD_READ) && data_slot) begin
            nxt.shift_reg = {state_i.shift_reg[i2cbe_pkg::ByteW-2:0], sda_in_i};
          end
          nxt.phase = '0;
          if (state_i.bit_index >= last_slot) begin
            done = 1'b1;
            if (state_i.active_cmd == i2cbe_pkg::CMD_WRITE) begin
              nack_out = nxt.nack;
            end
            if (state_i.active_cmd == i2cbe_pkg::CMD_READ) begin
              byte_out = nxt.shift_reg;
            end
            nxt.active_cmd = i2cbe_pkg::CMD_IDLE;
            nxt.bit_index  = '0;
          end else begin
            nxt.bit_index = state_i.bit_index + i2cbe_pkg::SlotW'(1);
          end
        end else begin
          nxt.phase = state_i.phase + i2cbe_pkg::PhaseW'(1);
        end
      end else begin
        nxt.tick_count = tick_inc[i2cbe_pkg::TickW-1:0];
      end
    end
  end

  assign state_o           = nxt;
  assign res_o.scl_level   = nxt.scl;
  assign res_o.sda_release = nxt.sda;
  assign res_o.busy_res    = nxt.active_cmd != i2cbe_pkg::CMD_IDLE;
  assign res_o.done_res    = done;
  assign res_o.nack_seen   = nack_out;
  assign res_o.read_byte   = byte_out;

endmodule

### sv/i2c_master_bit_engine.sv
// top level of the i2c bit engine: state, phase length register, result register
// depends on i2cbe_pkg, i2cbe_cmd_if, i2cbe_res_if, i2cbe_step, assert_macros.svh
//
//   port      dir  contents
//   cmd_i     in   kind, write_byte, send_ack, sda_in
//   res_o     out  scl_level, sda_release, busy_res, done_res, nack_seen, read_byte
//   cfg_*_i   in   phase_ticks, ticks per quarter bit phase
//
// one word in per clock while cmd_i.ready is high, its result registered in the output register
// the state update and result come from one pass of i2cbe_step
// cmd_i.ready is high while the output register is empty or being taken
// reset: phase_ticks 10, engine idle, scl and sda released, no result held

`include "assert_macros.svh"

module i2c_master_bit_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [i2cbe_pkg::TickW-1:0]   cfg_wdata_i,
  i2cbe_cmd_if.sink                     cmd_i,
  i2cbe_res_if.source                   res_o
);

  logic [i2cbe_pkg::TickW-1:0] phase_ticks_q;
  i2cbe_pkg::state_t           state_q;
  i2cbe_pkg::state_t           state_d;
  i2cbe_pkg::res_t             res_q;
  i2cbe_pkg::res_t             res_d;
  logic                        res_valid_q;
  logic                        accept;

  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;

  i2cbe_step u_step (
    .state_i       (state_q),
    .phase_ticks_i (phase_ticks_q),
    .kind_i        (cmd_i.kind),
    .write_byte_i  (cmd_i.write_byte),
    .send_ack_i    (cmd_i.send_ack),
    .sda_in_i      (cmd_i.sda_in),
    .state_o       (state_d),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= i2cbe_pkg::PHASE_TICKS_RST;
    end else if (cfg_we_i) begin
      phase_ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.tick_count <= '0;
      state_q.phase      <= '0;
      state_q.bit_index  <= '0;
      state_q.shift_reg  <= '0;
      state_q.active_cmd <= i2cbe_pkg::CMD_IDLE;
      state_q.ack_choice <= 1'b0;
      state_q.scl        <= 1'b1;
      state_q.sda        <= 1'b1;
      state_q.nack       <= 1'b0;
      res_valid_q        <= 1'b0;
    end else if (accept) begin
      state_q     <= state_d;
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.scl_level   = res_q.scl_level;
  assign res_o.sda_release = res_q.sda_release;
  assign res_o.busy_res    = res_q.busy_res;
  assign res_o.done_res    = res_q.done_res;
  assign res_o.nack_seen   = res_q.nack_seen;
  assign res_o.read_byte   = res_q.read_byte;

  `ASSERT_IMPLY(a_done_not_busy, clk_i, rst_ni, res_o.valid && res_o.done_res,
                !res_o.busy_res, "finished command still reported busy")
  `ASSERT_IMPLY(a_status_only_on_done, clk_i, rst_ni,
                res_o.valid && (res_o.nack_seen || (res_o.read_byte != '0)),
                res_o.done_res, "nack or read byte reported without done")
  `ASSERT_IMPLY(a_slot_range, clk_i, rst_ni, 1'b1,
                state_q.bit_index <= i2cbe_pkg::LAST_DATA_SLOT, "bit slot out of range")
  `ASSERT_NEXT(a_idle_pins_hold, clk_i, rst_ni,
               accept && (state_q.active_cmd == i2cbe_pkg::CMD_IDLE) &&
               (cmd_i.kind == i2cbe_pkg::KIND_TICK),
               (state_q.scl == $past(state_q.scl)) && (state_q.sda == $past(state_q.sda)),
               "pins moved on a tick while idle")

endmodule

### dv/i2c_master_bit_engine_tb.sv
// testbench for i2c_master_bit_engine: directed and random command/tick words
// with random stalls, every status word checked against a bus timing model
// depends on i2cbe_pkg, i2cbe_cmd_if, i2cbe_res_if and the rtl of the engine

module i2c_master_bit_engine_tb;

  localparam int CLK_HALF = 6;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int RAND_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 150;
  localparam logic [i2cbe_pkg::KindW-1:0] KIND_BAD_FIRST = 3'd5;
  localparam logic [i2cbe_pkg::KindW-1:0] KIND_BAD_LAST = 3'd7;

  typedef enum int {SDA_LOW, SDA_HIGH, SDA_RAND} sda_mode_e;

  class bus_scoreboard;
    logic [i2cbe_pkg::TickW-1:0] phase_len;
    logic [i2cbe_pkg::TickW-1:0] tick_cnt;
    logic [i2cbe_pkg::PhaseW-1:0] phase;
    logic [i2cbe_pkg::SlotW-1:0] slot;
    logic [i2cbe_pkg::ByteW-1:0] shreg;
    i2cbe_pkg::cmd_e cmd;
    logic ack_sel;
    logic scl;
    logic sda;
    logic nack;
    i2cbe_pkg::res_t status_q[$];
    int unsigned errors;

    function new();
      phase_len = i2cbe_pkg::PHASE_TICKS_RST;
      tick_cnt = '0;
      phase = '0;
      slot = '0;
      shreg = '0;
      cmd = i2cbe_pkg::CMD_IDLE;
      ack_sel = 1'b0;
      scl = 1'b1;
      sda = 1'b1;
      nack = 1'b0;
      errors = 0;
    endfunction

    function bit busy();
      return cmd != i2cbe_pkg::CMD_IDLE;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void advance_bus(logic [i2cbe_pkg::KindW-1:0] kind,
                              logic [i2cbe_pkg::ByteW-1:0] wbyte, logic sack,
                              logic sdain);
      logic done;
      logic nack_out;
      logic [i2cbe_pkg::ByteW-1:0] byte_out;
      logic [i2cbe_pkg::TickW-1:0] len;
      logic [i2cbe_pkg::SlotW-1:0] last;
      i2cbe_pkg::res_t want;
      done = 1'b0;
      nack_out = 1'b0;
      byte_out = '0;
      if (cmd == i2cbe_pkg::CMD_IDLE && kind >= i2cbe_pkg::CMD_START &&
          kind <= i2cbe_pkg::CMD_READ) begin
        cmd = i2cbe_pkg::cmd_e'(kind);
        tick_cnt = '0;
        phase = '0;
        slot = '0;
        ack_sel = sack;
        shreg = (cmd == i2cbe_pkg::CMD_WRITE) ? wbyte : '0;
        if (cmd == i2cbe_pkg::CMD_WRITE) nack = 1'b0;
      end else if (kind == i2cbe_pkg::KIND_TICK && cmd != i2cbe_pkg::CMD_IDLE) begin
        len = (phase_len == '0) ? i2cbe_pkg::TickW'(1) : phase_len;
        last = (cmd == i2cbe_pkg::CMD_WRITE || cmd == i2cbe_pkg::CMD_READ) ?
               i2cbe_pkg::LAST_DATA_SLOT : '0;
        case (cmd)
          i2cbe_pkg::CMD_START: begin
            scl = (phase == 2'd1 || phase == 2'd2);
            sda = (phase < 2'd2);
          end
          i2cbe_pkg::CMD_STOP: begin
            scl = (phase >= 2'd1);
            sda = (phase >= 2'd2);
          end
          i2cbe_pkg::CMD_WRITE: begin
            scl = (phase >= 2'd2);
            sda = (slot < i2cbe_pkg::LAST_DATA_SLOT) ? shreg[i2cbe_pkg::ByteW-1] : 1'b1;
          end
          i2cbe_pkg::CMD_READ: begin
            scl = (phase >= 2'd2);
            sda = (slot < i2cbe_pkg::LAST_DATA_SLOT) ? 1'b1 : !ack_sel;
          end
          default: ;
        endcase
        if (tick_cnt + 1 >= len) begin
          tick_cnt = '0;
          if (phase == i2cbe_pkg::LAST_PHASE) begin
            if (cmd == i2cbe_pkg::CMD_WRITE) begin
              if (slot < i2cbe_pkg::LAST_DATA_SLOT) shreg = {shreg[i2cbe_pkg::ByteW-2:0], 1'b0};
              else nack = sdain;
            end else if (cmd == i2cbe_pkg::CMD_READ && slot < i2cbe_pkg::LAST_DATA_SLOT) begin
              shreg = {shreg[i2cbe_pkg::ByteW-2:0], sdain};
            end
            if (slot >= last) begin
              done = 1'b1;
              if (cmd == i2cbe_pkg::CMD_WRITE) nack_out = nack;
              if (cmd == i2cbe_pkg::CMD_READ) byte_out = shreg;
              cmd = i2cbe_pkg::CMD_IDLE;
              slot = '0;
            end else begin
              slot = slot + 1'b1;
            end
            phase = '0;
          end else begin
            phase = phase + 1'b1;
          end
        end else begin
          tick_cnt = tick_cnt + 1'b1;
        end
      end
      want.scl_level = scl;
      want.sda_release = sda;
      want.busy_res = (cmd != i2cbe_pkg::CMD_IDLE);
      want.done_res = done;
      want.nack_seen = nack_out;
      want.read_byte = byte_out;
      status_q.push_back(want);
    endfunction

    function void mismatch(string field, logic [i2cbe_pkg::ByteW-1:0] want,
                           logic [i2cbe_pkg::ByteW-1:0] got);
      errors++;
      $display("%0t %s: expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_status(i2cbe_pkg::res_t got);
      i2cbe_pkg::res_t want;
      if (status_q.size() == 0) begin
        errors++;
        $display("%0t unexpected status word: actual %h", $time, got);
        return;
      end
      want = status_q.pop_front();
      if (got.scl_level !== want.scl_level)
        mismatch("scl_level", i2cbe_pkg::ByteW'(want.scl_level),
                 i2cbe_pkg::ByteW'(got.scl_level));
      if (got.sda_release !== want.sda_release)
        mismatch("sda_release", i2cbe_pkg::ByteW'(want.sda_release),
                 i2cbe_pkg::ByteW'(got.sda_release));
      if (got.busy_res !== want.busy_res)
        mismatch("busy_res", i2cbe_pkg::ByteW'(want.busy_res),
                 i2cbe_pkg::ByteW'(got.busy_res));
      if (got.done_res !== want.done_res)
        mismatch("done_res", i2cbe_pkg::ByteW'(want.done_res),
                 i2cbe_pkg::ByteW'(got.done_res));
      if (got.nack_seen !== want.nack_seen)
        mismatch("nack_seen", i2cbe_pkg::ByteW'(want.nack_seen),
                 i2cbe_pkg::ByteW'(got.nack_seen));
      if (got.read_byte !== want.read_byte)
        mismatch("read_byte", want.read_byte, got.read_byte);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [i2cbe_pkg::TickW-1:0] cfg_wdata_i;
  bit calm;
  logic [i2cbe_pkg::TickW-1:0] rand_lens [RAND_PHASES];
  bus_scoreboard sb = new();

  i2cbe_cmd_if cmd_if();
  i2cbe_res_if res_if();

  i2c_master_bit_engine u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_if),
    .res_o       (res_if)
  );

  always begin
    clk_i = 1'b0;
    #CLK_HALF;
    clk_i = 1'b1;
    #CLK_HALF;
  end

  function automatic bit hold_off();
    return !calm && ($urandom_range(0, 99) < 36);
  endfunction

  function automatic logic pick_sda(sda_mode_e mode);
    case (mode)
      SDA_LOW: return 1'b0;
      SDA_HIGH: return 1'b1;
      default: return 1'($urandom);
    endcase
  endfunction

  // status words, receiver stalls at random
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_status(i2cbe_pkg::res_t'({res_if.scl_level, res_if.sda_release,
                                         res_if.busy_res, res_if.done_res,
                                         res_if.nack_seen, res_if.read_byte}));
    res_if.ready <= !hold_off();
  end

  task automatic send_word(input logic [i2cbe_pkg::KindW-1:0] kind,
                           input logic [i2cbe_pkg::ByteW-1:0] wbyte,
                           input logic sack, input logic sdain);
    while (hold_off()) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.kind <= kind;
    cmd_if.write_byte <= wbyte;
    cmd_if.send_ack <= sack;
    cmd_if.sda_in <= sdain;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    sb.advance_bus(kind, wbyte, sack, sdain);
  endtask

  task automatic finish_cmd(input sda_mode_e mode);
    while (sb.busy())
      send_word(i2cbe_pkg::KIND_TICK, i2cbe_pkg::ByteW'($urandom), 1'($urandom),
                pick_sda(mode));
  endtask

  task automatic run_cmd(input logic [i2cbe_pkg::KindW-1:0] kind,
                         input logic [i2cbe_pkg::ByteW-1:0] wbyte,
                         input logic sack, input sda_mode_e mode);
    send_word(kind, wbyte, sack, 1'($urandom));
    finish_cmd(mode);
  endtask

  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_phase_len(input logic [i2cbe_pkg::TickW-1:0] len);
    finish_cmd(SDA_RAND);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.phase_len = len;
  endtask

  // mostly well-formed commands followed by ticks, some stray words
  task automatic random_word(output bit counted);
    logic [i2cbe_pkg::KindW-1:0] kind;
    int roll;
    roll = $urandom_range(0, 99);
    if (sb.busy()) begin
      kind = (roll < 92) ? i2cbe_pkg::KIND_TICK :
             i2cbe_pkg::KindW'($urandom_range(i2cbe_pkg::CMD_START, KIND_BAD_LAST));
      counted = (kind == i2cbe_pkg::KIND_TICK);
    end else begin
      if (roll < 80)
        kind = i2cbe_pkg::KindW'($urandom_range(i2cbe_pkg::CMD_START, i2cbe_pkg::CMD_READ));
      else if (roll < 88) kind = i2cbe_pkg::KIND_TICK;
      else kind = i2cbe_pkg::KindW'($urandom_range(KIND_BAD_FIRST, KIND_BAD_LAST));
      counted = (kind >= i2cbe_pkg::CMD_START && kind <= i2cbe_pkg::CMD_READ);
    end
    send_word(kind, i2cbe_pkg::ByteW'($urandom), 1'($urandom), 1'($urandom));
  endtask

  initial begin
    bit counted;
    int unsigned done_items;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    cmd_if.valid <= 1'b0;
    cmd_if.kind <= i2cbe_pkg::KIND_TICK;
    cmd_if.write_byte <= '0;
    cmd_if.send_ack <= 1'b0;
    cmd_if.sda_in <= 1'b0;
    calm = 1'b0;
    rand_lens = '{10'd1, 10'd2, 10'd1, 10'd3, 10'd0, 10'd5, 10'd4, 10'd2};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset phase length: idle words, reserved kinds, commands while busy
    send_word(i2cbe_pkg::KIND_TICK, 8'h00, 1'b0, 1'b0);
    for (int k = KIND_BAD_FIRST; k <= KIND_BAD_LAST; k++)
      send_word(i2cbe_pkg::KindW'(k), 8'hFF, 1'b1, 1'b1);
    send_word(i2cbe_pkg::CMD_START, 8'h00, 1'b0, 1'b1);
    send_word(i2cbe_pkg::CMD_STOP, 8'hFF, 1'b1, 1'b0);
    send_word(KIND_BAD_LAST, 8'h00, 1'b0, 1'b1);
    finish_cmd(SDA_RAND);

    // short phases for the directed byte commands
    set_phase_len(10'd1);
    run_cmd(i2cbe_pkg::CMD_WRITE, 8'hFF, 1'b0, SDA_HIGH);
    run_cmd(i2cbe_pkg::CMD_WRITE, 8'h00, 1'b1, SDA_LOW);
    run_cmd(i2cbe_pkg::CMD_WRITE, 8'h80, 1'b0, SDA_RAND);
    run_cmd(i2cbe_pkg::CMD_WRITE, 8'h01, 1'b1, SDA_RAND);
    run_cmd(i2cbe_pkg::CMD_READ, 8'h00, 1'b1, SDA_HIGH);
    run_cmd(i2cbe_pkg::CMD_READ, 8'hFF, 1'b0, SDA_LOW);
    run_cmd(i2cbe_pkg::CMD_READ, 8'h5A, 1'b1, SDA_RAND);
    run_cmd(i2cbe_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RAND);
    send_word(i2cbe_pkg::KIND_TICK, 8'hFF, 1'b1, 1'b1);

    // zero length acts as one tick
    set_phase_len('0);
    run_cmd(i2cbe_pkg::CMD_START, 8'h00, 1'b0, SDA_RAND);
    run_cmd(i2cbe_pkg::CMD_WRITE, 8'hC3, 1'b0, SDA_RAND);
    run_cmd(i2cbe_pkg::CMD_READ, 8'h00, 1'b0, SDA_RAND);
    run_cmd(i2cbe_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RAND);

    for (int p = 0; p < RAND_PHASES; p++) begin
      set_phase_len((p == 6) ? i2cbe_pkg::TickW'($urandom_range(4, 20)) : rand_lens[p]);
      calm = (p == 2);
      done_items = 0;
      while (done_items < ITEMS_PER_PHASE) begin
        random_word(counted);
        if (counted) done_items++;
      end
      calm = 1'b0;
    end

    finish_cmd(SDA_RAND);
    settle();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
